// File: design/pbc_pkg.sv
// Shared types and constants for the playout buffer controller.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package pbc_pkg;

  // Slot pool size default
  localparam int SLOTS_DEFAULT = 16;

  // Field widths
  localparam int ACT_W      = 2;
  localparam int USED_W     = 18;
  localparam int MINR_W     = 5;
  localparam int SYNC_W     = 20;
  localparam int WAIT_W     = 20;
  localparam int FRAME_W    = 19;
  localparam int ELAPSED_W  = 21;
  localparam int UNDER_W    = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int DROP_OUT_W = 5;
  localparam int MODE_W     = 2;

  // Port widths
  localparam int S_TDATA_W  = 24;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 56;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;

  // Result beat layout (bit offsets in m_tdata)
  localparam int OFS_SIL     = 4;
  localparam int OFS_DROPPED = 23;
  localparam int OFS_UNDER   = 30;
  localparam int OFS_MODE    = 47;

  // Register reset values
  localparam logic [MINR_W-1:0]  MIN_READY_RST   = MINR_W'(10);
  localparam logic [SYNC_W-1:0]  SYNC_TICKS_RST  = SYNC_W'(1000);
  localparam logic [WAIT_W-1:0]  BACKUP_WAIT_RST = WAIT_W'(5000);
  localparam logic [FRAME_W-1:0] FRAME_BYTES_RST = FRAME_W'(131072);

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIN_READY   = 2'd0,
    CFG_SYNC_TICKS  = 2'd1,
    CFG_BACKUP_WAIT = 2'd2,
    CFG_FRAME_BYTES = 2'd3
  } cfg_idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PRODUCE = 2'd0,
    ACT_CONSUME = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_NOP     = 2'd3
  } act_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WAIT = 2'd0,
    MODE_BUF  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PROD_CHECK,
    ST_DROP_RD,
    ST_DROP_WR,
    ST_FRONT_RD,
    ST_FRONT_TAKE,
    ST_POP_RD,
    ST_POP_TAKE,
    ST_APPEND,
    ST_CONS_EVAL,
    ST_CONS_TAKE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_item;
    logic tick;
    logic rd_tail;
    logic drop_push;
    logic front_take;
    logic pop_take;
    logic append;
    logic cons_eval;
    logic cons_take;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    act_t action;
    logic free_empty;
    logic playing;
    logic drop_more;
    logic drop_more_after;
    logic level_nz;
    logic level_after_nz;
    logic cons_take_needed;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: design/pbc_ctrl.sv
// Sequencer of the playout buffer controller.
// Depends on pbc_pkg; drives pbc_datapath through cmd_t and reads sts_t.
`default_nettype none

module pbc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  pbc_pkg::sts_t sts,
  output pbc_pkg::cmd_t cmd
);
  import pbc_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts.action)
          ACT_PRODUCE: state_next = ST_PROD_CHECK;
          ACT_CONSUME: state_next = ST_CONS_EVAL;
          default:     state_next = ST_FINISH;
        endcase
      end
      ST_PROD_CHECK: begin
        if (!sts.free_empty) begin
          state_next = ST_POP_RD;
        end else if (sts.playing && sts.drop_more) begin
          state_next = ST_DROP_RD;
        end else if (sts.level_nz) begin
          state_next = ST_FRONT_RD;
        end else begin
          state_next = ST_POP_RD;
        end
      end
      ST_DROP_RD: state_next = ST_DROP_WR;
      ST_DROP_WR: begin
        if (sts.drop_more_after) begin
          state_next = ST_DROP_RD;
        end else if (sts.level_after_nz) begin
          state_next = ST_FRONT_RD;
        end else begin
          state_next = ST_POP_RD;
        end
      end
      ST_FRONT_RD:   state_next = ST_FRONT_TAKE;
      ST_FRONT_TAKE: state_next = ST_APPEND;
      ST_POP_RD:     state_next = ST_POP_TAKE;
      ST_POP_TAKE:   state_next = ST_APPEND;
      ST_APPEND:     state_next = ST_FINISH;
      ST_CONS_EVAL: begin
        state_next = sts.cons_take_needed ? ST_CONS_TAKE : ST_FINISH;
      end
      ST_CONS_TAKE: state_next = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.latch_item = s_tvalid;
      end
      ST_DISPATCH:   cmd.tick       = (sts.action == ACT_TICK);
      ST_DROP_RD:    cmd.rd_tail    = 1'b1;
      ST_DROP_WR:    cmd.drop_push  = 1'b1;
      ST_FRONT_TAKE: cmd.front_take = 1'b1;
      ST_POP_TAKE:   cmd.pop_take   = 1'b1;
      ST_APPEND:     cmd.append     = 1'b1;
      ST_CONS_EVAL:  cmd.cons_eval  = 1'b1;
      ST_CONS_TAKE:  cmd.cons_take  = 1'b1;
      ST_FINISH:     cmd.load_out   = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: design/pbc_datapath.sv
// Datapath of the playout buffer controller: registers, ready ring, free stack,
// result register. Depends on pbc_pkg; steered by pbc_ctrl.
`default_nettype none

module pbc_datapath #(
  parameter int SLOTS = pbc_pkg::SLOTS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pbc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pbc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [pbc_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [pbc_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pbc_pkg::M_TDATA_W-1:0]    m_tdata,
  input  pbc_pkg::cmd_t                    cmd,
  output pbc_pkg::sts_t                    sts
);
  import pbc_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LVL_W  = $clog2(SLOTS + 1);
  localparam int SUM_W  = LVL_W + 1;
  localparam int CMP_W  = (LVL_W > MINR_W) ? LVL_W : MINR_W;

  // Configuration
  logic [MINR_W-1:0]  min_ready;
  logic [SYNC_W-1:0]  sync_ticks;
  logic [WAIT_W-1:0]  backup_wait_ticks;
  logic [FRAME_W-1:0] frame_bytes;

  // Item and control state
  act_t                act_q;
  logic [USED_W-1:0]   used_q;
  mode_t               mode;
  logic [SLOT_W-1:0]   head;
  logic [LVL_W-1:0]    level;
  logic [LVL_W-1:0]    free_level;
  logic [ELAPSED_W-1:0] elapsed;
  logic                backup_active;
  logic                backup_fired;
  logic [UNDER_W-1:0]  underrun_counter;
  logic [SLOT_W-1:0]   fill_slot;

  // Result under construction
  logic [SLOT_W-1:0]   res_slot;
  logic                res_sil;
  logic [USED_W-1:0]   res_played;
  logic [LVL_W-1:0]    res_dropped;
  logic                res_start;
  logic                res_stop;
  logic                res_under;

  // Memories
  logic [SLOT_W-1:0] ring_slot_mem  [SLOTS];
  logic [USED_W-1:0] ring_count_mem [SLOTS];
  logic [SLOT_W-1:0] free_mem       [SLOTS];
  logic [SLOTS-1:0]  free_written;
  logic [SLOT_W-1:0] ring_rd_slot;
  logic [USED_W-1:0] ring_rd_count;
  logic [SLOT_W-1:0] free_rd_data;
  logic              free_rd_written;
  logic [SLOT_W-1:0] free_rd_idx;
  logic [SLOT_W-1:0] free_top;

  // Address arithmetic
  logic [SUM_W-1:0]  sum_new;
  logic [SUM_W-1:0]  sum_last;
  logic [SLOT_W-1:0] tail_new;
  logic [SLOT_W-1:0] tail_last;
  logic [SLOT_W-1:0] ring_rd_addr;
  logic [SLOT_W-1:0] head_inc;
  logic [LVL_W-1:0]  level_m1;
  logic [LVL_W-1:0]  free_m1;
  logic              free_full;
  logic              level_full;
  logic              push_free;
  logic [SLOT_W-1:0] push_slot;

  // Consume decision
  logic  start_play;
  mode_t mode_after;
  logic  out_free;

  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [LVL_W+DROP_OUT_W-1:0]  drop_ext;

  // Ring positions
  always_comb begin
    sum_new   = SUM_W'(head) + SUM_W'(level);
    sum_last  = sum_new - SUM_W'(1);
    tail_new  = (sum_new >= SUM_W'(SLOTS)) ? SLOT_W'(sum_new - SUM_W'(SLOTS))
                                            : SLOT_W'(sum_new);
    tail_last = (sum_last >= SUM_W'(SLOTS)) ? SLOT_W'(sum_last - SUM_W'(SLOTS))
                                             : SLOT_W'(sum_last);
    head_inc  = (head == SLOT_W'(SLOTS - 1)) ? '0 : head + SLOT_W'(1);
    ring_rd_addr = cmd.rd_tail ? tail_last : head;
    level_m1  = level - LVL_W'(1);
    free_m1   = free_level - LVL_W'(1);
    free_full  = (free_level == LVL_W'(SLOTS));
    level_full = (level == LVL_W'(SLOTS));
    free_top  = free_rd_written ? free_rd_data : free_rd_idx;
  end

  // Start of playback on consume and the mode after it
  always_comb begin
    start_play = (mode == MODE_BUF) &&
                 (elapsed > ELAPSED_W'(sync_ticks)) &&
                 (CMP_W'(level) >= CMP_W'(min_ready));
    mode_after = start_play ? MODE_PLAY : mode;
  end

  assign out_free  = !m_tvalid || m_tready;
  assign push_free = (cmd.drop_push || cmd.cons_take) && !free_full;
  assign push_slot = ring_rd_slot;

  // Status towards the sequencer
  always_comb begin
    sts.action           = act_q;
    sts.free_empty       = (free_level == '0);
    sts.playing          = (mode == MODE_PLAY);
    sts.drop_more        = (CMP_W'(level) > CMP_W'(min_ready));
    sts.drop_more_after  = (CMP_W'(level_m1) > CMP_W'(min_ready));
    sts.level_nz         = (level != '0);
    sts.level_after_nz   = (level_m1 != '0);
    sts.cons_take_needed = (mode_after == MODE_PLAY) && (level != '0);
    sts.out_free         = out_free;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_ready         <= MIN_READY_RST;
      sync_ticks        <= SYNC_TICKS_RST;
      backup_wait_ticks <= BACKUP_WAIT_RST;
      frame_bytes       <= FRAME_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MIN_READY:   min_ready         <= cfg_wdata[MINR_W-1:0];
        CFG_SYNC_TICKS:  sync_ticks        <= cfg_wdata[SYNC_W-1:0];
        CFG_BACKUP_WAIT: backup_wait_ticks <= cfg_wdata[WAIT_W-1:0];
        CFG_FRAME_BYTES: frame_bytes       <= cfg_wdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append && !level_full) begin
      ring_slot_mem[tail_new]  <= fill_slot;
      ring_count_mem[tail_new] <= used_q;
    end
    ring_rd_slot  <= ring_slot_mem[ring_rd_addr];
    ring_rd_count <= ring_count_mem[ring_rd_addr];
  end

  // Free stack memory; an entry never pushed reads as its own index
  always_ff @(posedge clk) begin
    if (push_free) begin
      free_mem[free_level[SLOT_W-1:0]] <= push_slot;
    end
    free_rd_data <= free_mem[free_m1[SLOT_W-1:0]];
    free_rd_idx  <= free_m1[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_written    <= '0;
      free_rd_written <= 1'b0;
    end else begin
      if (push_free) begin
        free_written[free_level[SLOT_W-1:0]] <= 1'b1;
      end
      free_rd_written <= free_written[free_m1[SLOT_W-1:0]];
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      act_q  <= act_t'(s_tuser[ACT_W-1:0]);
      used_q <= s_tdata[USED_W-1:0];
    end
  end

  // Buffer state, mode, timers and result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_WAIT;
      head             <= '0;
      level            <= '0;
      free_level       <= LVL_W'(SLOTS);
      elapsed          <= '0;
      backup_active    <= 1'b1;
      backup_fired     <= 1'b0;
      underrun_counter <= '0;
      fill_slot        <= '0;
      res_slot         <= '0;
      res_sil          <= 1'b0;
      res_played       <= '0;
      res_dropped      <= '0;
      res_start        <= 1'b0;
      res_stop         <= 1'b0;
      res_under        <= 1'b0;
    end else begin
      // clear the result on a new beat
      if (cmd.latch_item) begin
        res_slot    <= '0;
        res_sil     <= 1'b0;
        res_played  <= '0;
        res_dropped <= '0;
        res_start   <= 1'b0;
        res_stop    <= 1'b0;
        res_under   <= 1'b0;
      end

      // advance time, saturating
      if (cmd.tick && (elapsed != ELAPSED_MAX)) begin
        elapsed <= elapsed + ELAPSED_W'(1);
      end

      // drop one frame from the tail onto the free stack
      if (cmd.drop_push) begin
        level       <= level_m1;
        res_dropped <= res_dropped + LVL_W'(1);
      end

      // recycle the oldest ready frame
      if (cmd.front_take) begin
        fill_slot <= ring_rd_slot;
        head      <= head_inc;
        level     <= level_m1;
      end

      // take the top of the free stack
      if (cmd.pop_take) begin
        if (free_level != '0) begin
          fill_slot  <= free_top;
          free_level <= free_m1;
        end else begin
          fill_slot <= '0;
        end
      end

      // append the filled slot and leave waiting
      if (cmd.append) begin
        if (!level_full) level <= level + LVL_W'(1);
        res_slot <= fill_slot;
        if (mode == MODE_WAIT) begin
          mode         <= MODE_BUF;
          elapsed      <= '0;
          backup_fired <= 1'b0;
        end
      end

      // consume: start playback, silence, backup request, underrun
      if (cmd.cons_eval) begin
        // an underrun while playing falls back to waiting
        mode <= ((mode_after == MODE_PLAY) && (level == '0)) ? MODE_WAIT : mode_after;
        if (start_play && backup_active) begin
          res_stop      <= 1'b1;
          backup_active <= 1'b0;
        end
        if (mode_after != MODE_PLAY) begin
          res_sil <= 1'b1;
          if (!backup_fired && (elapsed > ELAPSED_W'(backup_wait_ticks))) begin
            res_start     <= 1'b1;
            backup_active <= 1'b1;
            backup_fired  <= 1'b1;
          end
        end else if (level == '0) begin
          res_under    <= 1'b1;
          res_sil      <= 1'b1;
          elapsed      <= '0;
          backup_fired <= 1'b0;
          if (underrun_counter != '1) begin
            underrun_counter <= underrun_counter + UNDER_W'(1);
          end
        end
      end

      // consume: play the oldest frame and free its slot
      if (cmd.cons_take) begin
        res_slot   <= ring_rd_slot;
        res_played <= ring_rd_count;
        res_sil    <= ({ring_rd_count, 1'b0} != frame_bytes);
        head       <= head_inc;
        level      <= level_m1;
      end

      // free stack grows on every push
      if (push_free) begin
        free_level <= free_level + LVL_W'(1);
      end
    end
  end

  assign slot_ext = (SLOT_W + SLOT_OUT_W)'(res_slot);
  assign drop_ext = (LVL_W + DROP_OUT_W)'(res_dropped);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= M_TDATA_W'({mode, underrun_counter, res_under, res_stop, res_start,
                             drop_ext[DROP_OUT_W-1:0], res_played, res_sil,
                             slot_ext[SLOT_OUT_W-1:0]});
    end
  end

endmodule

`default_nettype wire

// File: design/playout_buffer_controller_top.sv
// Top level of the playout buffer controller.
// Depends on pbc_pkg, pbc_ctrl and pbc_datapath.
//
// Usage:
//   Input beats on s_* carry one item: s_tuser holds the action (produce,
//   consume, tick, no operation), s_tdata the sample count of a produced frame.
//   Every item gives exactly one result beat on m_*. The user writes registers
//   on cfg_* only while no item is in flight; the block does not enforce this.
// Sequencing:
//   A tick or no-operation item goes from dispatch to finish; a consume adds an
//   evaluation state and, to play a frame, a take state; a produce checks the free
//   stack, reads and pushes one tail frame per drop, then reads, takes and appends
//   a slot. The sequencer steps through one read of the ready ring or of the free
//   stack at a time, each with a registered read port.
// Reset:
//   Synchronous reset empties the ready queue, fills the free stack with all
//   slots, restores register defaults and clears the result register at once;
//   there is no clearing pass.
// Back-pressure:
//   The result register holds a beat while m_tready is low; the block still
//   takes one new item meanwhile and waits with its result until the register
//   is free.
`default_nettype none

module playout_buffer_controller_top #(
  parameter int SLOTS = pbc_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [pbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pbc_pkg::S_TDATA_W-1:0]  s_tdata,  // used_samples[17:0], zero [23:18]
  input  logic [pbc_pkg::S_TUSER_W-1:0]  s_tuser,  // action[1:0]
  // results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // slot[3:0], play_silence[4], played_samples[22:5], dropped[27:23],
  // start_backup[28], stop_backup[29], underrun[30], underrun_total[46:31],
  // mode[48:47], zero [55:49]
  output logic [pbc_pkg::M_TDATA_W-1:0]  m_tdata
);
  import pbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbc_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// File: design/pbc_checker.sv
// Port-level checks on the result channel of the playout buffer controller.
// Depends on pbc_pkg; bound to playout_buffer_controller_top.
`default_nettype none

module pbc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pbc_pkg::M_TDATA_W-1:0] m_tdata
);
  import pbc_pkg::*;

  logic [MODE_W-1:0] out_mode;
  assign out_mode = m_tdata[OFS_MODE +: MODE_W];

  // no result beat straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // a stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat withdrawn while stalled");

  // mode code is always a real mode
  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_mode == MODE_WAIT) || (out_mode == MODE_BUF) ||
                 (out_mode == MODE_PLAY))
    else $error("illegal mode code");

  // tail drops happen only while playing
  a_drop_playing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OFS_DROPPED +: DROP_OUT_W] != '0) |-> (out_mode == MODE_PLAY))
    else $error("frames dropped outside playback");

  // an underrun plays silence and falls back to waiting
  a_underrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OFS_UNDER] |-> m_tdata[OFS_SIL] && (out_mode == MODE_WAIT))
    else $error("underrun without silence or mode change");

endmodule

bind playout_buffer_controller_top pbc_checker u_pbc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: bench/playout_buffer_controller_top_tb.sv
// Self-checking bench for the playout buffer controller top level.
// Needs pbc_pkg and playout_buffer_controller_top; predicts every result beat
// from its own copy of the queue, free stack, timers and registers.
`timescale 1ns / 100ps

module playout_buffer_controller_top_tb;
  import pbc_pkg::*;

  localparam int NSLOT       = SLOTS_DEFAULT;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 400;

  // One input item as the driver offers it
  typedef struct packed {
    act_t        action;
    logic [17:0] used;
  } pb_item_t;

  // Result beat in m_tdata order, highest bits first
  typedef struct packed {
    logic [6:0]  pad;
    logic [1:0]  mode;
    logic [15:0] total;
    logic        under;
    logic        stop;
    logic        start;
    logic [4:0]  dropped;
    logic [17:0] played;
    logic        silence;
    logic [3:0]  slot;
  } pb_beat_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic [S_TUSER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;

  playout_buffer_controller_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Shadow state of the controller
  mode_t              m_mode;
  logic [3:0]         m_ring_slot [NSLOT];
  logic [17:0]        m_ring_cnt  [NSLOT];
  logic [3:0]         m_head;
  logic [4:0]         m_rdy_lvl;
  logic [3:0]         m_free      [NSLOT];
  logic [4:0]         m_free_lvl;
  logic [ELAPSED_W-1:0] m_elapsed;
  logic               m_bk_active;
  logic               m_bk_fired;
  logic [15:0]        m_under;
  logic [4:0]         m_min_ready;
  logic [19:0]        m_sync;
  logic [19:0]        m_bwait;
  logic [18:0]        m_frame;

  pb_item_t pending_actions [$];
  pb_beat_t predicted_reports [$];
  pb_item_t offered;
  int       n_queued    = 0;
  int       n_accepted  = 0;
  int       n_beats     = 0;
  int       n_errors    = 0;
  int       src_gap     = 0;
  int       snk_gap     = 0;
  int       hold_left   = 0;
  int       hold_beats  = 0;
  int       cycle_count = 0;
  bit       quiet       = 1'b0;

  string fld_name [9] = '{"slot", "play_silence", "played_samples", "dropped",
                          "start_backup", "stop_backup", "underrun",
                          "underrun_total", "mode"};

  // Gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  function automatic void free_push(input logic [3:0] s);
    if (m_free_lvl < NSLOT) begin
      m_free[m_free_lvl[3:0]] = s;
      m_free_lvl = m_free_lvl + 5'd1;
    end
  endfunction

  function automatic logic [3:0] free_pop();
    if (m_free_lvl == 0) return 4'd0;
    m_free_lvl = m_free_lvl - 5'd1;
    return m_free[m_free_lvl[3:0]];
  endfunction

  // Advance the shadow state by one item and form its report
  task automatic model_playout_step(input pb_item_t it, output pb_beat_t r);
    logic [3:0]  s;
    logic [3:0]  tail;
    logic [17:0] cnt;
    r = '0;
    case (it.action)
      ACT_PRODUCE: begin
        if (m_free_lvl == 0) begin
          // drop from the tail only while playing
          if (m_mode == MODE_PLAY) begin
            while (m_rdy_lvl > m_min_ready) begin
              tail = 4'(m_head + m_rdy_lvl - 5'd1);
              free_push(m_ring_slot[tail]);
              m_rdy_lvl = m_rdy_lvl - 5'd1;
              r.dropped = r.dropped + 5'd1;
            end
          end
          if (m_rdy_lvl > 0) begin
            s = m_ring_slot[m_head];
            m_head = m_head + 4'd1;
            m_rdy_lvl = m_rdy_lvl - 5'd1;
          end else begin
            s = free_pop();
          end
        end else begin
          s = free_pop();
        end
        if (m_rdy_lvl < NSLOT) begin
          tail = 4'(m_head + m_rdy_lvl);
          m_ring_slot[tail] = s;
          m_ring_cnt[tail]  = it.used;
          m_rdy_lvl = m_rdy_lvl + 5'd1;
        end
        r.slot = s;
        if (m_mode == MODE_WAIT) begin
          m_mode     = MODE_BUF;
          m_elapsed  = '0;
          m_bk_fired = 1'b0;
        end
      end
      ACT_CONSUME: begin
        if (m_mode == MODE_BUF && m_elapsed > m_sync && m_rdy_lvl >= m_min_ready) begin
          m_mode = MODE_PLAY;
          if (m_bk_active) begin
            r.stop      = 1'b1;
            m_bk_active = 1'b0;
          end
        end
        if (m_mode != MODE_PLAY) begin
          r.silence = 1'b1;
          if (!m_bk_fired && m_elapsed > m_bwait) begin
            r.start     = 1'b1;
            m_bk_active = 1'b1;
            m_bk_fired  = 1'b1;
          end
        end else if (m_rdy_lvl == 0) begin
          r.under = 1'b1;
          if (m_under != 16'hFFFF) m_under = m_under + 16'd1;
          m_elapsed  = '0;
          m_bk_fired = 1'b0;
          m_mode     = MODE_WAIT;
          r.silence  = 1'b1;
        end else begin
          s   = m_ring_slot[m_head];
          cnt = m_ring_cnt[m_head];
          m_head = m_head + 4'd1;
          m_rdy_lvl = m_rdy_lvl - 5'd1;
          r.slot   = s;
          r.played = cnt;
          if (32'(cnt) * 2 != 32'(m_frame)) r.silence = 1'b1;
          free_push(s);
        end
      end
      ACT_TICK: begin
        if (m_elapsed != ELAPSED_MAX) m_elapsed = m_elapsed + ELAPSED_W'(1);
      end
      default: ;
    endcase
    r.total = m_under;
    r.mode  = m_mode;
  endtask

  function automatic logic [17:0] beat_field(input pb_beat_t b, input int i);
    case (i)
      0: return 18'(b.slot);
      1: return 18'(b.silence);
      2: return b.played;
      3: return 18'(b.dropped);
      4: return 18'(b.start);
      5: return 18'(b.stop);
      6: return 18'(b.under);
      7: return 18'(b.total);
      default: return 18'(b.mode);
    endcase
  endfunction

  // Driver: offer queued items, hold each until taken, idle at random between beats
  always @(posedge clk) begin
    pb_beat_t pred;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        model_playout_step(offered, pred);
        predicted_reports.insert(predicted_reports.size(), pred);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_actions.size() != 0) begin
          offered = pending_actions[0];
          pending_actions.delete(0);
          s_tvalid <= 1'b1;
          s_tuser  <= offered.action;
          s_tdata  <= {6'b0, offered.used};
          src_gap  = gap_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs, counted in cycles
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_beats <= 0;
    end else begin
      if (m_tvalid && m_tready) hold_beats <= hold_beats + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (m_tvalid && m_tready &&
                   (hold_beats == 249 || hold_beats == 1099)) begin
        hold_left <= HOLD_CYCLES;
      end
    end
  end

  // Monitor: compare each result beat, stall at random
  always @(posedge clk) begin
    pb_beat_t got;
    pb_beat_t want;
    int i;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = pb_beat_t'(m_tdata);
        if (predicted_reports.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, m_tdata);
          n_errors++;
        end else begin
          want = predicted_reports[0];
          predicted_reports.delete(0);
          for (i = 0; i < 9; i++) begin
            if (beat_field(got, i) !== beat_field(want, i)) begin
              $display("%0t: beat %0d %s expected %0d actual %0d", $time, n_beats,
                       fld_name[i], beat_field(want, i), beat_field(got, i));
              n_errors++;
            end
          end
        end
        n_beats++;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        snk_gap = gap_len();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_item(input act_t a, input logic [17:0] u);
    pb_item_t it;
    it.action = a;
    it.used   = u;
    pending_actions.insert(pending_actions.size(), it);
    n_queued++;
  endtask

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(input cfg_idx_t idx, input logic [19:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MIN_READY:   m_min_ready = val[4:0];
      CFG_SYNC_TICKS:  m_sync      = val;
      CFG_BACKUP_WAIT: m_bwait     = val;
      default:         m_frame     = val[18:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off the sender until every report is back
  task automatic wait_drained();
    while (n_accepted != n_queued || predicted_reports.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Sample count: mostly one that fills the frame exactly
  function automatic logic [17:0] pick_used(input logic [18:0] fb);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return fb[18:1];
    if (r < 80) return 18'($urandom_range(0, 131072));
    if (r < 90) return r[0] ? 18'd0 : 18'd131072;
    return 18'($urandom);
  endfunction

  // Runs of produces, ticks and consumes with some mixed and noisy stretches
  task automatic random_phase(input int n_items, input logic [18:0] fb);
    int   left;
    int   len;
    int   k;
    int   r;
    int   w;
    act_t a;
    left = n_items;
    while (left > 0) begin
      r   = $urandom_range(0, 9);
      len = $urandom_range(1, 20);
      for (k = 0; k < len && left > 0; k++) begin
        case (r)
          0, 1, 2: queue_item(ACT_PRODUCE, pick_used(fb));
          3, 4:    queue_item(ACT_TICK, 18'($urandom));
          5, 6:    queue_item(ACT_CONSUME, 18'($urandom));
          7, 8: begin
            w = $urandom_range(0, 99);
            a = (w < 40) ? ACT_PRODUCE : (w < 75) ? ACT_CONSUME :
                (w < 97) ? ACT_TICK : ACT_NOP;
            queue_item(a, pick_used(fb));
          end
          default: queue_item(act_t'($urandom_range(0, 3)), 18'($urandom));
        endcase
        left--;
      end
    end
  endtask

  initial begin
    int i;
    int p;
    int mr;
    int sy;
    int bw;
    int fb;
    // Shadow state after reset
    m_mode      = MODE_WAIT;
    m_head      = '0;
    m_rdy_lvl   = '0;
    for (i = 0; i < NSLOT; i++) m_free[i] = 4'(i);
    m_free_lvl  = 5'(NSLOT);
    m_elapsed   = '0;
    m_bk_active = 1'b1;
    m_bk_fired  = 1'b0;
    m_under     = '0;
    m_min_ready = MIN_READY_RST;
    m_sync      = SYNC_TICKS_RST;
    m_bwait     = BACKUP_WAIT_RST;
    m_frame     = FRAME_BYTES_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Defaults: idle actions, sample count extremes, consume while buffering
    queue_item(ACT_NOP, 18'h3FFFF);
    queue_item(ACT_CONSUME, 18'd0);
    queue_item(ACT_TICK, 18'd0);
    queue_item(ACT_PRODUCE, 18'd0);
    queue_item(ACT_PRODUCE, 18'd131072);
    queue_item(ACT_PRODUCE, 18'h3FFFF);
    queue_item(ACT_CONSUME, 18'd0);
    queue_item(ACT_TICK, 18'h3FFFF);
    queue_item(ACT_NOP, 18'd0);
    wait_drained();

    // Start playing with stop pulse, size mismatches, underrun, a matching frame
    write_reg(CFG_MIN_READY, 20'd1);
    write_reg(CFG_SYNC_TICKS, 20'd0);
    write_reg(CFG_BACKUP_WAIT, 20'd2);
    write_reg(CFG_FRAME_BYTES, 20'd4);
    queue_item(ACT_TICK, 18'd0);
    repeat (4) queue_item(ACT_CONSUME, 18'd0);
    queue_item(ACT_PRODUCE, 18'd2);
    queue_item(ACT_CONSUME, 18'd0);
    repeat (3) queue_item(ACT_TICK, 18'd0);
    repeat (2) queue_item(ACT_CONSUME, 18'd0);
    wait_drained();

    // Too few ready frames: silence and the backup request
    write_reg(CFG_MIN_READY, 20'd16);
    queue_item(ACT_PRODUCE, 18'd2);
    repeat (3) queue_item(ACT_TICK, 18'd0);
    repeat (2) queue_item(ACT_CONSUME, 18'd0);
    wait_drained();

    // Random phases over a spread of settings, extremes first
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin mr = 0;  sy = 0;       bw = 0;       fb = 2;      end
        1: begin mr = 16; sy = 3;       bw = 1048575; fb = 262144; end
        2: begin mr = 4;  sy = 1048575; bw = 5;       fb = 100;    end
        3: begin mr = 10; sy = 5;       bw = 20;      fb = 131072; end
        4: begin mr = 0;  sy = 1;       bw = 0;       fb = 262144; end
        default: begin
          mr = $urandom_range(0, 16);
          sy = $urandom_range(0, 12);
          bw = $urandom_range(0, 60);
          fb = ($urandom_range(0, 7) == 0) ? 2 * $urandom_range(1, 131071) + 1
                                           : 2 * $urandom_range(1, 131072);
        end
      endcase
      write_reg(CFG_MIN_READY, 20'(mr));
      write_reg(CFG_SYNC_TICKS, 20'(sy));
      write_reg(CFG_BACKUP_WAIT, 20'(bw));
      write_reg(CFG_FRAME_BYTES, 20'(fb));
      // one phase runs flat out on both sides
      quiet = (p == 3);
      random_phase(200, 19'(fb));
      wait_drained();
    end

    // Let any stray beat show before the verdict
    repeat (60) @(posedge clk);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/pbc_pkg.sv
design/pbc_ctrl.sv
design/pbc_datapath.sv
design/playout_buffer_controller_top.sv
design/pbc_checker.sv
bench/playout_buffer_controller_top_tb.sv
